// ----- hdl/kjq_pkg.sv -----
// ----------------------------------------------------------------------------
// kjq_pkg
// Shared types and codes for the keyed job queue and its cells.
// ----------------------------------------------------------------------------
package kjq_pkg;

    localparam int DEPTH_DEF     = 16;
    localparam int KEY_BITS_DEF  = 64;
    localparam int PAGE_BITS_DEF = 16;

    localparam int OP_FIELD_W   = 3;
    localparam int KEY_FIELD_W  = 64;
    localparam int PAGE_FIELD_W = 16;
    localparam int STAT_FIELD_W = 3;

    localparam int JOB_KEY_LSB = OP_FIELD_W;
    localparam int NEW_KEY_LSB = JOB_KEY_LSB + KEY_FIELD_W;
    localparam int PAGES_LSB   = NEW_KEY_LSB + KEY_FIELD_W;
    localparam int IN_BITS     = PAGES_LSB + PAGE_FIELD_W;
    localparam int IN_DATA_W   = ((IN_BITS + 7) / 8) * 8;

    localparam int OUT_KEY_LSB   = STAT_FIELD_W;
    localparam int OUT_PAGES_LSB = OUT_KEY_LSB + KEY_FIELD_W;
    localparam int OUT_BITS      = OUT_PAGES_LSB + PAGE_FIELD_W;
    localparam int OUT_DATA_W    = ((OUT_BITS + 7) / 8) * 8;

    typedef enum logic [OP_FIELD_W-1:0] {
        OP_ADD     = 3'd0,
        OP_EDIT    = 3'd1,
        OP_PROCESS = 3'd2,
        OP_CANCEL  = 3'd3,
        OP_VIEW    = 3'd4
    } t_op;

    typedef enum logic [STAT_FIELD_W-1:0] {
        STAT_OK      = 3'd0,
        STAT_FULL    = 3'd1,
        STAT_DUP     = 3'd2,
        STAT_EMPTY   = 3'd3,
        STAT_MISSING = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_ADD,
        CMD_EDIT,
        CMD_POP,
        CMD_REMOVE,
        CMD_ROTATE
    } t_cell_cmd;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_VIEW
    } t_state;

    // passed from a cell toward the head
    typedef struct packed {
        logic occ;
        logic mark;
        logic hit_any;
    } t_up_link;

    // passed from a cell toward the tail
    typedef struct packed {
        logic occ;
        logic rm;
    } t_dn_link;

endpackage

// ----- hdl/kjq_cell.sv -----
// ----------------------------------------------------------------------------
// kjq_cell
// One queue slot: key, pages, occupancy, compare hit and view mark.
// ----------------------------------------------------------------------------
module kjq_cell #(
    parameter int KEY_BITS  = kjq_pkg::KEY_BITS_DEF,
    parameter int PAGE_BITS = kjq_pkg::PAGE_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  kjq_pkg::t_cell_cmd    i_cmd,
    input  logic [KEY_BITS-1:0]   i_job_key,
    input  logic [KEY_BITS-1:0]   i_new_key,
    input  logic [PAGE_BITS-1:0]  i_pages,
    input  logic [KEY_BITS-1:0]   i_head_key,
    input  logic [PAGE_BITS-1:0]  i_head_pages,
    input  logic                  i_head_mark,
    input  logic [KEY_BITS-1:0]   i_up_key,
    input  logic [PAGE_BITS-1:0]  i_up_pages,
    input  kjq_pkg::t_up_link     i_up,
    input  kjq_pkg::t_dn_link     i_dn,
    output logic [KEY_BITS-1:0]   o_key,
    output logic [PAGE_BITS-1:0]  o_pages,
    output kjq_pkg::t_up_link     o_up,
    output kjq_pkg::t_dn_link     o_dn
);

    logic                 r_occ;
    logic                 r_hit;
    logic                 r_mark;
    logic [KEY_BITS-1:0]  r_key;
    logic [PAGE_BITS-1:0] r_pages;

    logic w_target;
    logic w_tail;
    logic w_shift;

    assign w_target = r_hit & ~i_up.hit_any;
    assign w_tail   = r_occ & ~i_up.occ;
    assign w_shift  = (i_cmd == kjq_pkg::CMD_POP) ||
                      ((i_cmd == kjq_pkg::CMD_REMOVE) && (i_dn.rm || w_target));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ  <= 1'b0;
            r_hit  <= 1'b0;
            r_mark <= 1'b0;
        end else begin
            case (i_cmd)
                kjq_pkg::CMD_LOAD: begin
                    r_hit  <= r_occ && (r_key == i_job_key);
                    r_mark <= w_tail;
                end
                kjq_pkg::CMD_ADD: begin
                    if (!r_occ && i_dn.occ) begin
                        r_occ <= 1'b1;
                    end
                end
                kjq_pkg::CMD_POP, kjq_pkg::CMD_REMOVE: begin
                    if (w_shift) begin
                        r_occ <= i_up.occ;
                    end
                end
                kjq_pkg::CMD_ROTATE: begin
                    if (r_occ) begin
                        r_mark <= w_tail ? i_head_mark : i_up.mark;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd)
            kjq_pkg::CMD_ADD: begin
                if (!r_occ && i_dn.occ) begin
                    r_key   <= i_job_key;
                    r_pages <= i_pages;
                end
            end
            kjq_pkg::CMD_EDIT: begin
                if (w_target) begin
                    r_key   <= i_new_key;
                    r_pages <= i_pages;
                end
            end
            kjq_pkg::CMD_POP, kjq_pkg::CMD_REMOVE: begin
                if (w_shift) begin
                    r_key   <= i_up_key;
                    r_pages <= i_up_pages;
                end
            end
            kjq_pkg::CMD_ROTATE: begin
                if (r_occ) begin
                    r_key   <= w_tail ? i_head_key : i_up_key;
                    r_pages <= w_tail ? i_head_pages : i_up_pages;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_key          = r_key;
    assign o_pages        = r_pages;
    assign o_up.occ       = r_occ;
    assign o_up.mark      = r_mark;
    assign o_up.hit_any   = r_hit | i_up.hit_any;
    assign o_dn.occ       = r_occ;
    assign o_dn.rm        = i_dn.rm | w_target;

endmodule

// ----- hdl/keyed_job_queue.sv -----
// ----------------------------------------------------------------------------
// keyed_job_queue
// FIFO job queue of DEPTH slots with key search, edit, cancel and view.
// ----------------------------------------------------------------------------
// Add, edit, process and cancel pass through the accept cycle, in which
// every cell compares its key with the item's key, and the execute state,
// which resolves the match nearest the tail along the cell chain and shifts
// or writes the cells. A non-empty view then enters the view state, where
// the queue rotates one slot per cycle while the output is free, to stream
// the head out. Items are taken only in the idle state. A waiting result
// stalls view and execute, bar a non-empty view's execute, but not accept.
module keyed_job_queue #(
    parameter int DEPTH     = kjq_pkg::DEPTH_DEF,
    parameter int KEY_BITS  = kjq_pkg::KEY_BITS_DEF,
    parameter int PAGE_BITS = kjq_pkg::PAGE_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // operation, job_key, new_key, page_count
    input  logic [kjq_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // status, out_key, out_pages
    output logic [kjq_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    output logic                            m_axis_tlast
);

    localparam int KW = kjq_pkg::KEY_FIELD_W;
    localparam int PW = kjq_pkg::PAGE_FIELD_W;
    localparam int DW = kjq_pkg::OUT_DATA_W;

    kjq_pkg::t_state  r_state, n_state;

    logic [kjq_pkg::OP_FIELD_W-1:0] r_op;
    logic [KEY_BITS-1:0]            r_job_key;
    logic [KEY_BITS-1:0]            r_new_key;
    logic [PAGE_BITS-1:0]           r_pages;

    logic                           r_out_valid;
    kjq_pkg::t_status               r_out_status;
    logic [KW-1:0]                  r_out_key;
    logic [PW-1:0]                  r_out_pages;
    logic                           r_out_last;

    logic                           w_accept;
    logic                           w_out_free;
    logic                           w_load;
    kjq_pkg::t_status               w_status;
    logic                           w_emit_head;
    logic                           w_last;
    kjq_pkg::t_cell_cmd             w_cmd;
    logic [KEY_BITS-1:0]            w_cmp_key;
    logic [KEY_BITS-1:0]            w_add_key;

    kjq_pkg::t_up_link              w_up    [DEPTH+1];
    kjq_pkg::t_dn_link              w_dn    [DEPTH+1];
    logic [KEY_BITS-1:0]            w_key   [DEPTH+1];
    logic [PAGE_BITS-1:0]           w_pgs   [DEPTH+1];
    logic [DEPTH-1:0]               w_occ;

    logic w_empty, w_full, w_any_hit;

    assign w_accept   = s_axis_tvalid && s_axis_tready;
    assign w_out_free = !r_out_valid || m_axis_tready;

    assign w_empty   = !w_up[0].occ;
    assign w_full    = w_up[DEPTH-1].occ;
    assign w_any_hit = w_up[0].hit_any;

    // key compared in the accept cycle comes straight from the bus
    assign w_cmp_key = (r_state == kjq_pkg::S_IDLE) ?
                       s_axis_tdata[kjq_pkg::JOB_KEY_LSB +: KEY_BITS] : r_job_key;
    assign w_add_key = w_cmp_key;

    assign w_up[DEPTH]  = '0;
    assign w_key[DEPTH] = '0;
    assign w_pgs[DEPTH] = '0;
    assign w_dn[0].occ  = 1'b1;
    assign w_dn[0].rm   = 1'b0;

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        kjq_cell #(
            .KEY_BITS  (KEY_BITS),
            .PAGE_BITS (PAGE_BITS)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_cmd        (w_cmd),
            .i_job_key    (w_add_key),
            .i_new_key    (r_new_key),
            .i_pages      (r_pages),
            .i_head_key   (w_key[0]),
            .i_head_pages (w_pgs[0]),
            .i_head_mark  (w_up[0].mark),
            .i_up_key     (w_key[g+1]),
            .i_up_pages   (w_pgs[g+1]),
            .i_up         (w_up[g+1]),
            .i_dn         (w_dn[g]),
            .o_key        (w_key[g]),
            .o_pages      (w_pgs[g]),
            .o_up         (w_up[g]),
            .o_dn         (w_dn[g+1])
        );
        assign w_occ[g] = w_up[g].occ;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            kjq_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_state = kjq_pkg::S_EXEC;
                end
            end
            kjq_pkg::S_EXEC: begin
                case (r_op)
                    kjq_pkg::OP_ADD, kjq_pkg::OP_EDIT, kjq_pkg::OP_PROCESS,
                    kjq_pkg::OP_CANCEL: begin
                        if (w_out_free) begin
                            n_state = kjq_pkg::S_IDLE;
                        end
                    end
                    kjq_pkg::OP_VIEW: begin
                        if (!w_empty) begin
                            n_state = kjq_pkg::S_VIEW;
                        end else if (w_out_free) begin
                            n_state = kjq_pkg::S_IDLE;
                        end
                    end
                    default: begin
                        n_state = kjq_pkg::S_IDLE;
                    end
                endcase
            end
            kjq_pkg::S_VIEW: begin
                if (w_out_free && w_up[0].mark) begin
                    n_state = kjq_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = kjq_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        s_axis_tready = 1'b0;
        w_cmd         = kjq_pkg::CMD_NONE;
        w_load        = 1'b0;
        w_status      = kjq_pkg::STAT_OK;
        w_emit_head   = 1'b0;
        w_last        = 1'b1;
        case (r_state)
            kjq_pkg::S_IDLE: begin
                s_axis_tready = i_rst_n;
                if (w_accept) begin
                    w_cmd = kjq_pkg::CMD_LOAD;
                end
            end
            kjq_pkg::S_EXEC: begin
                case (r_op)
                    kjq_pkg::OP_ADD: begin
                        w_load = w_out_free;
                        if (w_full) begin
                            w_status = kjq_pkg::STAT_FULL;
                        end else if (w_any_hit) begin
                            w_status = kjq_pkg::STAT_DUP;
                        end else if (w_out_free) begin
                            w_cmd = kjq_pkg::CMD_ADD;
                        end
                    end
                    kjq_pkg::OP_EDIT, kjq_pkg::OP_CANCEL: begin
                        w_load = w_out_free;
                        if (w_empty) begin
                            w_status = kjq_pkg::STAT_EMPTY;
                        end else if (!w_any_hit) begin
                            w_status = kjq_pkg::STAT_MISSING;
                        end else if (w_out_free) begin
                            w_cmd = (r_op == kjq_pkg::OP_EDIT) ?
                                    kjq_pkg::CMD_EDIT : kjq_pkg::CMD_REMOVE;
                        end
                    end
                    kjq_pkg::OP_PROCESS: begin
                        w_load = w_out_free;
                        if (w_empty) begin
                            w_status = kjq_pkg::STAT_EMPTY;
                        end else begin
                            w_emit_head = 1'b1;
                            if (w_out_free) begin
                                w_cmd = kjq_pkg::CMD_POP;
                            end
                        end
                    end
                    kjq_pkg::OP_VIEW: begin
                        if (w_empty) begin
                            w_load   = w_out_free;
                            w_status = kjq_pkg::STAT_EMPTY;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            kjq_pkg::S_VIEW: begin
                w_load      = w_out_free;
                w_emit_head = 1'b1;
                w_last      = w_up[0].mark;
                if (w_out_free) begin
                    w_cmd = kjq_pkg::CMD_ROTATE;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= kjq_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op      <= s_axis_tdata[kjq_pkg::OP_FIELD_W-1:0];
            r_job_key <= s_axis_tdata[kjq_pkg::JOB_KEY_LSB +: KEY_BITS];
            r_new_key <= s_axis_tdata[kjq_pkg::NEW_KEY_LSB +: KEY_BITS];
            r_pages   <= s_axis_tdata[kjq_pkg::PAGES_LSB +: PAGE_BITS];
        end
        if (w_load) begin
            r_out_status <= w_status;
            r_out_key    <= w_emit_head ? KW'(w_key[0]) : '0;
            r_out_pages  <= w_emit_head ? PW'(w_pgs[0]) : '0;
            r_out_last   <= w_last;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tlast  = r_out_last;
    assign m_axis_tdata  = DW'({r_out_pages, r_out_key, r_out_status});

    // occupancy is a thermometer from the head
    a_occ_thermo: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((w_occ & (w_occ + 1'b1)) == '0))
        else $error("occupancy not contiguous from head");

    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == kjq_pkg::S_EXEC))
        else $error("accepted item not executed next cycle");

    a_pop_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd == kjq_pkg::CMD_POP || w_cmd == kjq_pkg::CMD_REMOVE) |=>
        ($countones(w_occ) + 1 == $countones($past(w_occ))))
        else $error("removal did not drop exactly one entry");

    a_view_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == kjq_pkg::S_VIEW) |=> $stable(w_occ))
        else $error("view changed occupancy");

    a_add_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd == kjq_pkg::CMD_ADD) |=>
        ($countones(w_occ) == $countones($past(w_occ)) + 1))
        else $error("add did not grow queue by one");

endmodule
